// ===== design/multiquadratic_squared_length_macros.svh =====
// ----------------------------------------------------------------------------
// Multiquadratic squared length: assertion macros
// Clocked assertion helpers shared by the merge stage and the top level.
// ----------------------------------------------------------------------------
`ifndef MULTIQUADRATIC_SQUARED_LENGTH_MACROS_SVH
`define MULTIQUADRATIC_SQUARED_LENGTH_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define MQSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Signal holds its value in the cycle after the condition.
`define MQSL_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

// ===== design/mqsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiquadratic squared length: package
// Basis radicals, target reset values, lane weights and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsl_pkg;

  localparam int NCOEF     = 8;
  localparam int NREG      = 8;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int REG_SEL_W = $clog2(NREG);
  localparam int NSTG      = 4;

  localparam int RAD [NCOEF] = '{1, 3, 5, 15, 11, 33, 55, 165};

  localparam logic [WORD_W-1:0] TGT_RESET [NREG] =
    '{32'd61, 32'd0, 32'd0, 32'd4, 32'd0, 32'd0, 32'd0, 32'd0};

  localparam logic [CFG_IDX_W-1:0] REG_C0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C7 = 4'd7;

  typedef logic [NCOEF-1:0][WORD_W-1:0] word_vec_t;

  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

  // Weight of term x[i]*x[i^k] in output coefficient k; zero drops the term.
  function automatic int lane_weight(input int k, input int i);
    int j;
    int w;
    j = i ^ k;
    w = 0;
    if (k == 0) begin
      w = RAD[i];
    end else if (i < j) begin
      w = 2 * RAD[i & j];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/mqsl_lane.sv =====
// ----------------------------------------------------------------------------
// Multiquadratic squared length: coefficient lane
// Forms one output coefficient: products, radical weighting, two half sums.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsl_lane #(
  parameter int COEF_BITS = 8,
  parameter int LANE      = 0
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic signed [COEF_BITS:0]      vx_i [mqsl_pkg::NCOEF],
  input  wire logic signed [COEF_BITS:0]      vy_i [mqsl_pkg::NCOEF],
  output logic        [mqsl_pkg::WORD_W-1:0]  half0_o,
  output logic        [mqsl_pkg::WORD_W-1:0]  half1_o
);
  import mqsl_pkg::*;

  localparam int DW = COEF_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int HALF = NCOEF / 2;
  localparam logic [REG_SEL_W-1:0] LANE_SEL = REG_SEL_W'(LANE);

  logic signed [PW-1:0]   px_d [NCOEF];
  logic signed [PW-1:0]   py_d [NCOEF];
  logic signed [PW-1:0]   px_q [NCOEF];
  logic signed [PW-1:0]   py_q [NCOEF];
  logic [WORD_W-1:0]      w_d  [NCOEF];
  logic [WORD_W-1:0]      w_q  [NCOEF];
  logic [WORD_W-1:0]      h0_d, h1_d, h0_q, h1_q;

  always_comb begin
    logic [REG_SEL_W-1:0] j;
    for (int i = 0; i < NCOEF; i++) begin
      j = REG_SEL_W'(i) ^ LANE_SEL;
      if (lane_weight(LANE, i) != 0) begin
        px_d[i] = PW'(vx_i[i]) * PW'(vx_i[j]);
        py_d[i] = PW'(vy_i[i]) * PW'(vy_i[j]);
      end else begin
        px_d[i] = '0;
        py_d[i] = '0;
      end
    end
  end

  always_comb begin
    logic signed [PW:0] s;
    for (int i = 0; i < NCOEF; i++) begin
      s = (PW+1)'(px_q[i]) + (PW+1)'(py_q[i]);
      w_d[i] = WORD_W'(WORD_W'(s) * WORD_W'(lane_weight(LANE, i)));
    end
  end

  always_comb begin
    h0_d = '0;
    h1_d = '0;
    for (int i = 0; i < HALF; i++) begin
      h0_d = h0_d + w_q[i];
      h1_d = h1_d + w_q[i+HALF];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      w_q  <= w_d;
      h0_q <= h0_d;
      h1_q <= h1_d;
    end
  end

  assign half0_o = h0_q;
  assign half1_o = h1_q;

endmodule

`default_nettype wire

// ===== design/mqsl_merge.sv =====
// ----------------------------------------------------------------------------
// Multiquadratic squared length: merge stage
// Joins lane half sums, compares against the target registers, holds output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multiquadratic_squared_length_macros.svh"

module mqsl_merge (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mqsl_pkg::pipe_ctl_t               ctl_i,
  input  wire mqsl_pkg::word_vec_t               half0_i,
  input  wire mqsl_pkg::word_vec_t               half1_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [mqsl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mqsl_pkg::WORD_W-1:0]       cfg_data_i,
  output logic                                   out_valid_o,
  output mqsl_pkg::word_vec_t                    sq_o,
  output logic                                   match_o
);
  import mqsl_pkg::*;

  logic [WORD_W-1:0] tgt_q [NREG];
  word_vec_t         sq_d, sq_q;
  logic              match_d, match_q;
  logic              out_valid_q;

  always_comb begin
    match_d = 1'b1;
    for (int k = 0; k < NCOEF; k++) begin
      sq_d[k] = half0_i[k] + half1_i[k];
      if (sq_d[k] != tgt_q[k]) begin
        match_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= TGT_RESET;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NREG))) begin
      tgt_q[cfg_idx_i[REG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.advance) begin
      out_valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      sq_q    <= sq_d;
      match_q <= match_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sq_o        = sq_q;
  assign match_o     = match_q;

  `MQSL_ASSERT(a_cfg_c0, cfg_we_i && cfg_idx_i == REG_C0 |=> tgt_q[0] == $past(cfg_data_i), "target c0 write lost")
  `MQSL_ASSERT(a_match_c7, out_valid_q && match_q |-> sq_q[NCOEF-1] == tgt_q[NCOEF-1], "match flag without equal c7")
  `MQSL_ASSERT(a_match_c0, out_valid_q && match_q && !(cfg_we_i && cfg_idx_i == REG_C0) |=> !out_valid_q || !match_q || sq_q[0] == tgt_q[0], "match flag without equal c0")

endmodule

`default_nettype wire

// ===== design/multiquadratic_squared_length.sv =====
// ----------------------------------------------------------------------------
// Multiquadratic squared length: top level
// Registers: input, lane product, weight and half sum, merge output.
// Throughput: one transaction per cycle unless stalled; 8 coefficient lanes.
// A stalled output freezes the whole pipeline and stalls the input side.
// Reset clears valid state and loads the target registers; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multiquadratic_squared_length_macros.svh"

module multiquadratic_squared_length #(
  parameter int COEF_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              mode_i,
  input  wire logic [63:0]                       first_x_i,
  input  wire logic [63:0]                       first_y_i,
  input  wire logic [63:0]                       second_x_i,
  input  wire logic [63:0]                       second_y_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [mqsl_pkg::WORD_W-1:0]     sq_c0_o,
  output logic signed [mqsl_pkg::WORD_W-1:0]     sq_c1_o,
  output logic signed [mqsl_pkg::WORD_W-1:0]     sq_c2_o,
  output logic signed [mqsl_pkg::WORD_W-1:0]     sq_c3_o,
  output logic signed [mqsl_pkg::WORD_W-1:0]     sq_c4_o,
  output logic signed [mqsl_pkg::WORD_W-1:0]     sq_c5_o,
  output logic signed [mqsl_pkg::WORD_W-1:0]     sq_c6_o,
  output logic signed [mqsl_pkg::WORD_W-1:0]     sq_c7_o,
  output logic                                   matches_target_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mqsl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mqsl_pkg::WORD_W-1:0]       cfg_data_i
);
  import mqsl_pkg::*;

  localparam int DW    = COEF_BITS + 1;
  localparam int EXT_W = 64 + NCOEF * COEF_BITS;

  logic                        adv;
  logic [NSTG-1:0]             v_q;
  logic [EXT_W-1:0]            fx_ext, fy_ext, sx_ext, sy_ext;
  logic signed [COEF_BITS-1:0] fx [NCOEF];
  logic signed [COEF_BITS-1:0] fy [NCOEF];
  logic signed [COEF_BITS-1:0] sx [NCOEF];
  logic signed [COEF_BITS-1:0] sy [NCOEF];
  logic signed [DW-1:0]        vx_d [NCOEF];
  logic signed [DW-1:0]        vy_d [NCOEF];
  logic signed [DW-1:0]        vx_q [NCOEF];
  logic signed [DW-1:0]        vy_q [NCOEF];
  word_vec_t                   half0, half1, sq;
  pipe_ctl_t                   ctl;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign fx_ext = EXT_W'(first_x_i);
  assign fy_ext = EXT_W'(first_y_i);
  assign sx_ext = EXT_W'(second_x_i);
  assign sy_ext = EXT_W'(second_y_i);

  always_comb begin
    for (int k = 0; k < NCOEF; k++) begin
      fx[k] = fx_ext[k*COEF_BITS +: COEF_BITS];
      fy[k] = fy_ext[k*COEF_BITS +: COEF_BITS];
      sx[k] = sx_ext[k*COEF_BITS +: COEF_BITS];
      sy[k] = sy_ext[k*COEF_BITS +: COEF_BITS];
      if (mode_i) begin
        vx_d[k] = DW'(fx[k]) - DW'(sx[k]);
        vy_d[k] = DW'(fy[k]) - DW'(sy[k]);
      end else begin
        vx_d[k] = DW'(fx[k]);
        vy_d[k] = DW'(fy[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
    end
  end

  for (genvar k = 0; k < NCOEF; k++) begin : g_lane
    mqsl_lane #(
      .COEF_BITS (COEF_BITS),
      .LANE      (k)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .vx_i    (vx_q),
      .vy_i    (vy_q),
      .half0_o (half0[k]),
      .half1_o (half1[k])
    );
  end

  assign ctl.advance = adv;
  assign ctl.valid   = v_q[NSTG-1];

  mqsl_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .half0_i     (half0),
    .half1_i     (half1),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .sq_o        (sq),
    .match_o     (matches_target_o)
  );

  assign sq_c0_o = sq[0];
  assign sq_c1_o = sq[1];
  assign sq_c2_o = sq[2];
  assign sq_c3_o = sq[3];
  assign sq_c4_o = sq[4];
  assign sq_c5_o = sq[5];
  assign sq_c6_o = sq[6];
  assign sq_c7_o = sq[7];

  `MQSL_ASSERT(a_enter, in_valid_i && !in_stall_o |=> v_q[0], "accepted transaction not in first stage")
  `MQSL_ASSERT_HOLD(a_freeze, !adv, v_q, "pipeline moved while output stalled")
  `MQSL_ASSERT(a_leave, v_q[NSTG-1] && adv |=> out_valid_o, "last stage transaction lost before output")

endmodule

`default_nettype wire

// ===== tb/sv/mqsl_sq_length_checker.sv =====
// ----------------------------------------------------------------------------
// Multiquadratic squared length: result checker
// Watches the input, output and register write ports of the block. For each
// accepted input transaction it computes the eight squared length
// coefficients and the target match flag, and holds them in arrival order.
// Each accepted result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module mqsl_sq_length_checker #(
  parameter int COEF_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              mode_i,
  input  logic [63:0]                       first_x_i,
  input  logic [63:0]                       first_y_i,
  input  logic [63:0]                       second_x_i,
  input  logic [63:0]                       second_y_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       sq_c0_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       sq_c1_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       sq_c2_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       sq_c3_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       sq_c4_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       sq_c5_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       sq_c6_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       sq_c7_i,
  input  logic                              matches_target_i,
  input  logic                              cfg_we_i,
  input  logic [mqsl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mqsl_pkg::WORD_W-1:0]       cfg_data_i,
  output int                                fail_count_o,
  output int                                outstanding_o
);
  import mqsl_pkg::*;

  typedef struct packed {
    word_vec_t coef;
    logic      hit;
  } sq_length_t;

  localparam longint RADICAL [NCOEF] = '{1, 3, 5, 15, 11, 33, 55, 165};
  localparam logic [WORD_W-1:0] TARGET_AT_RESET [NREG] =
    '{32'd61, 32'd0, 32'd0, 32'd4, 32'd0, 32'd0, 32'd0, 32'd0};

  logic [WORD_W-1:0] target_regs [NREG];
  sq_length_t        sq_length_q [$];
  int                mismatch_cnt = 0;

  function automatic longint coef_of(input logic [63:0] word, input int idx);
    longint raw;
    int     pos;
    pos = idx * COEF_BITS;
    if (pos >= 64) return 0;
    raw = longint'(word >> pos);
    return (raw <<< (64 - COEF_BITS)) >>> (64 - COEF_BITS);
  endfunction

  function automatic sq_length_t predict_sq_length(input logic diff,
                                                   input logic [63:0] ax,
                                                   input logic [63:0] ay,
                                                   input logic [63:0] bx,
                                                   input logic [63:0] by);
    longint     vx  [NCOEF];
    longint     vy  [NCOEF];
    longint     acc [NCOEF];
    sq_length_t res;
    for (int k = 0; k < NCOEF; k++) begin
      vx[k] = coef_of(ax, k);
      vy[k] = coef_of(ay, k);
      if (diff) begin
        vx[k] -= coef_of(bx, k);
        vy[k] -= coef_of(by, k);
      end
      acc[k] = 0;
    end
    for (int i = 0; i < NCOEF; i++) begin
      for (int j = 0; j < NCOEF; j++) begin
        acc[i ^ j] += (vx[i] * vx[j] + vy[i] * vy[j]) * RADICAL[i & j];
      end
    end
    res.hit = 1'b1;
    for (int k = 0; k < NCOEF; k++) begin
      res.coef[k] = WORD_W'(acc[k]);
      if (res.coef[k] != target_regs[k]) res.hit = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_vec_t  got;
    sq_length_t want;
    logic       bad;
    if (!rst_ni) begin
      for (int k = 0; k < NREG; k++) target_regs[k] <= TARGET_AT_RESET[k];
      sq_length_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < CFG_IDX_W'(NREG)) begin
        target_regs[cfg_idx_i[REG_SEL_W-1:0]] <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        sq_length_q.push_back(predict_sq_length(mode_i, first_x_i, first_y_i,
                                                second_x_i, second_y_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = {sq_c7_i, sq_c6_i, sq_c5_i, sq_c4_i, sq_c3_i, sq_c2_i, sq_c1_i, sq_c0_i};
        if (sq_length_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("sq_length error at %0t: result with no pending transaction,"
                     , $realtime, " c7..c0=%h hit=%b", got, matches_target_i);
          end
        end else begin
          want = sq_length_q.pop_front();
          bad  = (matches_target_i !== want.hit);
          for (int k = 0; k < NCOEF; k++) begin
            if (got[k] !== want.coef[k]) bad = 1'b1;
          end
          if (bad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("sq_length error at %0t: c7..c0=%h hit=%b, wanted c7..c0=%h hit=%b",
                       $realtime, got, matches_target_i, want.coef, want.hit);
            end
          end
        end
      end
      fail_count_o  <= mismatch_cnt;
      outstanding_o <= sq_length_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Multiquadratic squared length: testbench top
// Drives directed vectors at the coefficient extremes, the target match and
// the difference mode, then four random phases with different sender and
// receiver idling and different target settings. Results are checked by a
// separate checker module; this module only drives and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mqsl_pkg::*;

  localparam int COEF_BITS     = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 490;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {HIT_NONE, HIT_PYTHAGOREAN, HIT_UNIT_SQRT15} hit_shape_e;

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      mode_i     = 1'b0;
  logic [63:0]               first_x_i  = '0;
  logic [63:0]               first_y_i  = '0;
  logic [63:0]               second_x_i = '0;
  logic [63:0]               second_y_i = '0;
  logic                      out_stall_i = 1'b0;
  logic                      cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i  = '0;
  logic [WORD_W-1:0]         cfg_data_i = '0;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic signed [WORD_W-1:0]  sq_c0_o, sq_c1_o, sq_c2_o, sq_c3_o;
  logic signed [WORD_W-1:0]  sq_c4_o, sq_c5_o, sq_c6_o, sq_c7_o;
  logic                      matches_target_o;

  int         fail_count;
  int         outstanding;
  int         cycle_cnt      = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  hit_shape_e hit_shape      = HIT_UNIT_SQRT15;

  always #1 clk_i = ~clk_i;

  multiquadratic_squared_length #(
    .COEF_BITS (COEF_BITS)
  ) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i,
    .out_valid_o, .out_stall_i,
    .sq_c0_o, .sq_c1_o, .sq_c2_o, .sq_c3_o, .sq_c4_o, .sq_c5_o, .sq_c6_o, .sq_c7_o,
    .matches_target_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  mqsl_sq_length_checker #(
    .COEF_BITS (COEF_BITS)
  ) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i (in_stall_o), .mode_i,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i,
    .out_valid_i (out_valid_o), .out_stall_i,
    .sq_c0_i (sq_c0_o), .sq_c1_i (sq_c1_o), .sq_c2_i (sq_c2_o), .sq_c3_i (sq_c3_o),
    .sq_c4_i (sq_c4_o), .sq_c5_i (sq_c5_o), .sq_c6_i (sq_c6_o), .sq_c7_i (sq_c7_o),
    .matches_target_i (matches_target_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o (fail_count), .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("multiquadratic_squared_length: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] pack_coefs(input int c [NCOEF]);
    logic [63:0] w;
    for (int k = 0; k < NCOEF; k++) w[8*k +: 8] = 8'(c[k]);
    return w;
  endfunction

  task automatic send_item(input logic m, input logic [63:0] fx, input logic [63:0] fy,
                           input logic [63:0] sx, input logic [63:0] sy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    first_x_i  <= fx;
    first_y_i  <= fy;
    second_x_i <= sx;
    second_y_i <= sy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold the sender until every pending transaction has produced its result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic program_targets(input logic [WORD_W-1:0] vals [NREG]);
    for (int k = 0; k < NREG; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_C0 + CFG_IDX_W'(k);
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    // index past the register list: dropped by the block
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, NREG));
    cfg_data_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_item();
    int          vx [NCOEF];
    int          vy [NCOEF];
    int          bx [NCOEF];
    int          by [NCOEF];
    int          roll;
    int          a;
    int          b;
    int          sgn;
    logic        m;
    logic [63:0] fx;
    logic [63:0] fy;
    logic [63:0] sx;
    logic [63:0] sy;
    roll = $urandom_range(99);
    m    = 1'($urandom_range(1));
    fx   = {$urandom, $urandom};
    fy   = {$urandom, $urandom};
    sx   = {$urandom, $urandom};
    sy   = {$urandom, $urandom};
    if (roll < 40) begin
      for (int k = 0; k < NCOEF; k++) begin
        vx[k] = int'($urandom_range(6)) - 3;
        vy[k] = int'($urandom_range(6)) - 3;
      end
      if (roll < 20 && hit_shape != HIT_NONE) begin
        vx = '{default: 0};
        vy = '{default: 0};
        if (hit_shape == HIT_PYTHAGOREAN) begin
          case ($urandom_range(3))
            0: begin a = 5; b = 0; end
            1: begin a = 0; b = 5; end
            2: begin a = 3; b = 4; end
            default: begin a = 4; b = 3; end
          endcase
          vx[0] = $urandom_range(1) ? a : -a;
          vy[0] = $urandom_range(1) ? b : -b;
        end else begin
          sgn = $urandom_range(1) ? 1 : -1;
          if ($urandom_range(1)) begin
            vx[0] = sgn;
            vx[3] = 2 * sgn;
          end else begin
            vy[0] = sgn;
            vy[3] = 2 * sgn;
          end
        end
      end
      if (m) begin
        for (int k = 0; k < NCOEF; k++) begin
          bx[k] = int'($urandom_range(127)) - 64;
          by[k] = int'($urandom_range(127)) - 64;
          vx[k] += bx[k];
          vy[k] += by[k];
        end
        sx = pack_coefs(bx);
        sy = pack_coefs(by);
      end
      fx = pack_coefs(vx);
      fy = pack_coefs(vy);
    end
    send_item(m, fx, fy, sx, sy);
  endtask

  initial begin
    logic [WORD_W-1:0] tgt [NREG];
    logic [63:0]       r0;
    logic [63:0]       r1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    r0 = {$urandom, $urandom};
    r1 = {$urandom, $urandom};
    send_item(1'b0, 64'h0, 64'h0, r0, r1);
    send_item(1'b0, 64'h0000_0000_0200_0001, 64'h0, r1, r0);
    send_item(1'b0, 64'h0, 64'h0000_0000_FE00_00FF, r0, r0);
    send_item(1'b0, {8{8'h80}}, {8{8'h80}}, r1, r1);
    send_item(1'b0, {8{8'h7F}}, {8{8'h7F}}, r0, r1);
    send_item(1'b1, {8{8'h7F}}, {8{8'h7F}}, {8{8'h80}}, {8{8'h80}});
    send_item(1'b1, {8{8'h80}}, {8{8'h80}}, {8{8'h7F}}, {8{8'h7F}});
    send_item(1'b1, r0, r1, r0, r1);
    send_item(1'b1, 64'h1010_1010_1212_1011, {8{8'h10}}, {8{8'h10}}, {8{8'h10}});
    for (int k = 0; k < NCOEF; k++) begin
      send_item(1'b0, 64'h01 << (8 * k), 64'hFF << (8 * (NCOEF - 1 - k)), r1, r0);
    end
    send_item(1'b0, {4{16'h807F}}, {4{16'h7F80}}, r0, r1);
    send_item(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    send_item(1'b0, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          tgt = '{default: '0};
          tgt[0] = 32'd25;
          hit_shape = HIT_PYTHAGOREAN;
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          for (int k = 0; k < NREG; k++) tgt[k] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
          hit_shape = HIT_NONE;
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          tgt = '{32'd61, 32'd0, 32'd0, 32'd4, 32'd0, 32'd0, 32'd0, 32'd0};
          hit_shape = HIT_UNIT_SQRT15;
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          for (int k = 0; k < NREG; k++) tgt[k] = $urandom;
          hit_shape = HIT_NONE;
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      program_targets(tgt);
      repeat (PHASE_ITEMS) send_random_item();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("multiquadratic_squared_length: match");
    end else begin
      $display("multiquadratic_squared_length: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/mqsl_pkg.sv
design/mqsl_lane.sv
design/mqsl_merge.sv
design/multiquadratic_squared_length.sv
tb/sv/mqsl_sq_length_checker.sv
tb/sv/tb_top.sv
